FILE: hdl/cbb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbb_pkg: shared definitions for the circular byte buffer
// Operation codes, the store banking constants and the control word handed
// from the pointer stage to the output stage.
// ----------------------------------------------------------------------------
package cbb_pkg;

  // Default sizes for the top level parameters.
  localparam int DEF_STORE_DEPTH    = 1024;
  localparam int DEF_BYTES_PER_ITEM = 8;

  // The store is split into eight byte-wide banks, indexed by sequence number.
  localparam int NUM_BANKS = 8;
  localparam int LANE_W    = 3;
  localparam int BYTE_W    = 8;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_SKIP  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Control word of a request that has passed the pointer stage.
  typedef struct packed {
    logic              valid;
    logic              accepted;
    logic [LANE_W-1:0] lane;   // bank that holds the oldest byte read
    logic [LANE_W:0]   count;  // bytes read, zero for anything but a read
  } stage_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/cbb_bank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbb_bank: one byte-wide bank of the store
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module cbb_bank import cbb_pkg::*; #(
  parameter int ROW_W = 7
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ROW_W-1:0]  wr_row,
  input  wire logic [BYTE_W-1:0] wr_byte,
  input  wire logic [ROW_W-1:0]  rd_row,
  output logic      [BYTE_W-1:0] rd_byte_r
);

  logic [BYTE_W-1:0] mem [2**ROW_W];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_byte;
    end
    rd_byte_r <= mem[rd_row];
  end

endmodule
`default_nettype wire

FILE: hdl/cbb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbb_ctrl: request decode and pointer stage
// Checks each request against the fill level, updates positions, sequence
// counters and fill count, and drives the bank write and read ports.
// ----------------------------------------------------------------------------
module cbb_ctrl import cbb_pkg::*; #(
  parameter int STORE_DEPTH    = DEF_STORE_DEPTH,
  parameter int BYTES_PER_ITEM = DEF_BYTES_PER_ITEM,
  localparam int PW = $clog2(STORE_DEPTH),
  localparam int CW = $clog2(STORE_DEPTH + 1),
  localparam int SW = (PW < LANE_W + 1) ? LANE_W + 1 : PW,
  localparam int RW = SW - LANE_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [1:0]                    in_op,
  input  wire logic [CW:0]                   in_count,
  input  wire logic [BYTE_W*BYTES_PER_ITEM-1:0] in_write_data,
  input  wire logic                          cfg_wr_en,
  input  wire logic [CW-1:0]                 cfg_used_size,
  output logic                               busy,
  output stage_ctl_t                         ctl_r,
  output logic      [CW-1:0]                 moved_r,
  output logic      [CW-1:0]                 fill,
  output logic      [CW-1:0]                 free,
  output logic      [PW-1:0]                 rpos,
  output logic      [PW-1:0]                 wpos,
  output logic                               wr_en   [NUM_BANKS],
  output logic      [RW-1:0]                 wr_row  [NUM_BANKS],
  output logic      [BYTE_W-1:0]             wr_byte [NUM_BANKS],
  output logic      [RW-1:0]                 rd_row  [NUM_BANKS]
);

  localparam int NW = CW + 4;

  logic            busy_r;
  logic [CW-1:0]   size_r, size_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [PW-1:0]   rpos_r, rpos_nxt;
  logic [PW-1:0]   wpos_r, wpos_nxt;
  logic [SW-1:0]   rseq_r, rseq_nxt;
  logic [SW-1:0]   wseq_r, wseq_nxt;
  stage_ctl_t      ctl_nxt;
  logic [CW-1:0]   moved_nxt;

  op_t             op;
  logic            accept;
  logic            negative;
  logic [CW-1:0]   n;
  logic            fits_item;
  logic            fits_free;
  logic            fits_fill;
  logic            ok;
  logic [CW-1:0]   free_now;
  logic [CW:0]     wsum, rsum;
  logic [PW-1:0]   wpos_adv, rpos_adv;
  logic [LANE_W-1:0] woff [NUM_BANKS];
  logic [BYTE_W*NUM_BANKS-1:0] wd_ext;

  assign accept   = start && !busy_r;
  assign op       = op_t'(in_op);
  assign negative = in_count[CW];
  assign n        = in_count[CW-1:0];
  assign free_now = size_r - fill_r;

  assign fits_item = (NW'(n) <= NW'(BYTES_PER_ITEM));
  assign fits_free = (n <= free_now);
  assign fits_fill = (n <= fill_r);

  // Decide whether the request is carried out.
  always_comb begin
    case (op)
      OP_WRITE: ok = !negative && fits_item && fits_free;
      OP_READ:  ok = !negative && fits_item && fits_fill;
      OP_SKIP:  ok = !negative && fits_fill;
      OP_CLEAR: ok = 1'b1;
      default:  ok = 1'b0;
    endcase
  end

  // Position advance with a single wrap at the used size.
  assign wsum     = (CW+1)'(wpos_r) + (CW+1)'(n);
  assign rsum     = (CW+1)'(rpos_r) + (CW+1)'(n);
  assign wpos_adv = (wsum >= (CW+1)'(size_r)) ? PW'(wsum - (CW+1)'(size_r)) : PW'(wsum);
  assign rpos_adv = (rsum >= (CW+1)'(size_r)) ? PW'(rsum - (CW+1)'(size_r)) : PW'(rsum);

  // Next state of pointers, counters and the stage control word.
  always_comb begin
    size_nxt  = size_r;
    fill_nxt  = fill_r;
    rpos_nxt  = rpos_r;
    wpos_nxt  = wpos_r;
    rseq_nxt  = rseq_r;
    wseq_nxt  = wseq_r;
    moved_nxt = '0;
    ctl_nxt   = '0;
    if (cfg_wr_en) begin
      // A new used size also empties the buffer.
      if (cfg_used_size == '0) begin
        size_nxt = CW'(1);
      end else if (cfg_used_size > CW'(STORE_DEPTH)) begin
        size_nxt = CW'(STORE_DEPTH);
      end else begin
        size_nxt = cfg_used_size;
      end
      fill_nxt = '0;
      rpos_nxt = '0;
      wpos_nxt = '0;
      rseq_nxt = '0;
      wseq_nxt = '0;
    end else if (accept) begin
      ctl_nxt.valid    = 1'b1;
      ctl_nxt.accepted = ok;
      ctl_nxt.lane     = rseq_r[LANE_W-1:0];
      if (ok) begin
        case (op)
          OP_WRITE: begin
            fill_nxt  = fill_r + n;
            wpos_nxt  = wpos_adv;
            wseq_nxt  = wseq_r + SW'(n);
            moved_nxt = n;
          end
          OP_READ: begin
            fill_nxt      = fill_r - n;
            rpos_nxt      = rpos_adv;
            rseq_nxt      = rseq_r + SW'(n);
            moved_nxt     = n;
            ctl_nxt.count = (LANE_W+1)'(n);
          end
          OP_SKIP: begin
            fill_nxt  = fill_r - n;
            rpos_nxt  = rpos_adv;
            rseq_nxt  = rseq_r + SW'(n);
            moved_nxt = n;
          end
          OP_CLEAR: begin
            fill_nxt = '0;
            rpos_nxt = '0;
            wpos_nxt = '0;
            rseq_nxt = '0;
            wseq_nxt = '0;
          end
          default: begin
            fill_nxt = fill_r;
          end
        endcase
      end
    end
  end

  // Bank ports: bytes are spread over the banks by sequence number, so any
  // run of up to eight consecutive bytes touches each bank at most once.
  assign wd_ext = (BYTE_W*NUM_BANKS)'(in_write_data);

  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      woff[b]    = LANE_W'(b) - wseq_r[LANE_W-1:0];
      wr_en[b]   = accept && !cfg_wr_en && ok && (op == OP_WRITE) &&
                   (NW'(woff[b]) < NW'(n));
      wr_byte[b] = wd_ext[{woff[b], 3'b000} +: BYTE_W];
      wr_row[b]  = wseq_r[SW-1:LANE_W] +
                   RW'(LANE_W'(b) < wseq_r[LANE_W-1:0]);
      rd_row[b]  = rseq_r[SW-1:LANE_W] +
                   RW'(LANE_W'(b) < rseq_r[LANE_W-1:0]);
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      size_r  <= CW'(STORE_DEPTH);
      fill_r  <= '0;
      rpos_r  <= '0;
      wpos_r  <= '0;
      rseq_r  <= '0;
      wseq_r  <= '0;
      ctl_r   <= '0;
      moved_r <= '0;
    end else begin
      busy_r  <= 1'b0;
      size_r  <= size_nxt;
      fill_r  <= fill_nxt;
      rpos_r  <= rpos_nxt;
      wpos_r  <= wpos_nxt;
      rseq_r  <= rseq_nxt;
      wseq_r  <= wseq_nxt;
      ctl_r   <= ctl_nxt;
      moved_r <= moved_nxt;
    end
  end

  assign busy = busy_r;
  assign fill = fill_r;
  assign free = free_now;
  assign rpos = rpos_r;
  assign wpos = wpos_r;

endmodule
`default_nettype wire

FILE: hdl/cbb_outreg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbb_outreg: read alignment and result register
// Rotates the bank outputs so the oldest byte lands in byte 0, masks bytes
// beyond the read count and registers the whole result.
// ----------------------------------------------------------------------------
module cbb_outreg import cbb_pkg::*; #(
  parameter int STORE_DEPTH    = DEF_STORE_DEPTH,
  parameter int BYTES_PER_ITEM = DEF_BYTES_PER_ITEM,
  localparam int PW = $clog2(STORE_DEPTH),
  localparam int CW = $clog2(STORE_DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire stage_ctl_t            ctl,
  input  wire logic [CW-1:0]         moved,
  input  wire logic [CW-1:0]         fill,
  input  wire logic [CW-1:0]         free,
  input  wire logic [PW-1:0]         rpos,
  input  wire logic [PW-1:0]         wpos,
  input  wire logic [BYTE_W-1:0]     bank_byte [NUM_BANKS],
  output logic                       out_strobe,
  output logic                       out_accepted,
  output logic [BYTE_W*BYTES_PER_ITEM-1:0] out_read_data,
  output logic [CW-1:0]              out_moved,
  output logic [CW-1:0]              out_fill_level,
  output logic [CW-1:0]              out_free_space,
  output logic [PW-1:0]              out_read_position,
  output logic [PW-1:0]              out_write_position
);

  logic [BYTE_W*BYTES_PER_ITEM-1:0] rdata_nxt;
  logic [LANE_W-1:0]                bank_sel [BYTES_PER_ITEM];

  // Byte i of the result comes from the bank i places after the first one.
  always_comb begin
    for (int i = 0; i < BYTES_PER_ITEM; i++) begin
      bank_sel[i] = ctl.lane + LANE_W'(i);
      if ((LANE_W+1)'(i) < ctl.count) begin
        rdata_nxt[i*BYTE_W +: BYTE_W] = bank_byte[bank_sel[i]];
      end else begin
        rdata_nxt[i*BYTE_W +: BYTE_W] = '0;
      end
    end
  end

  // Result register; the strobe is the only bit that is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= ctl.valid;
    end
    out_accepted       <= ctl.accepted;
    out_read_data      <= rdata_nxt;
    out_moved          <= moved;
    out_fill_level     <= fill;
    out_free_space     <= free;
    out_read_position  <= rpos;
    out_write_position <= wpos;
  end

endmodule
`default_nettype wire

FILE: hdl/circular_byte_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circular_byte_buffer: ring byte store with write, read, skip and clear
// All-or-nothing transfers of up to BYTES_PER_ITEM bytes in, up to
// BYTES_PER_ITEM bytes out, or any held count dropped, with wrap at a
// programmable used size.
//
//   channel   ports                          handshake
//   request   in_op, in_count, in_write_data start high, busy low
//   result    out_*                          out_strobe, one cycle
//   config    cfg_used_size                  cfg_wr_en
//
// One request is taken every cycle while busy and cfg_wr_en are low; its
// result passes the registered read of the byte banks and then the result
// register.
// busy is high only in the first cycle after reset; nothing else stalls.
// Reset is synchronous and empties the buffer with a used size of
// STORE_DEPTH. A config write also empties the buffer.
// ----------------------------------------------------------------------------
module circular_byte_buffer import cbb_pkg::*; #(
  parameter int STORE_DEPTH    = DEF_STORE_DEPTH,
  parameter int BYTES_PER_ITEM = DEF_BYTES_PER_ITEM,
  localparam int PW = $clog2(STORE_DEPTH),
  localparam int CW = $clog2(STORE_DEPTH + 1),
  localparam int SW = (PW < LANE_W + 1) ? LANE_W + 1 : PW,
  localparam int RW = SW - LANE_W
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       in_op,
  input  wire logic [CW:0]                      in_count,
  input  wire logic [BYTE_W*BYTES_PER_ITEM-1:0] in_write_data,
  output logic                                  out_strobe,
  output logic                                  out_accepted,
  output logic [BYTE_W*BYTES_PER_ITEM-1:0]      out_read_data,
  output logic [CW-1:0]                         out_moved,
  output logic [CW-1:0]                         out_fill_level,
  output logic [CW-1:0]                         out_free_space,
  output logic [PW-1:0]                         out_read_position,
  output logic [PW-1:0]                         out_write_position,
  input  wire logic                             cfg_wr_en,
  input  wire logic [CW-1:0]                    cfg_used_size
);

  stage_ctl_t        ctl;
  logic [CW-1:0]     moved, fill, free;
  logic [PW-1:0]     rpos, wpos;
  logic              wr_en     [NUM_BANKS];
  logic [RW-1:0]     wr_row    [NUM_BANKS];
  logic [BYTE_W-1:0] wr_byte   [NUM_BANKS];
  logic [RW-1:0]     rd_row    [NUM_BANKS];
  logic [BYTE_W-1:0] bank_byte [NUM_BANKS];

  // Request decode and pointers.
  cbb_ctrl #(
    .STORE_DEPTH    (STORE_DEPTH),
    .BYTES_PER_ITEM (BYTES_PER_ITEM)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_op         (in_op),
    .in_count      (in_count),
    .in_write_data (in_write_data),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_used_size (cfg_used_size),
    .busy          (busy),
    .ctl_r         (ctl),
    .moved_r       (moved),
    .fill          (fill),
    .free          (free),
    .rpos          (rpos),
    .wpos          (wpos),
    .wr_en         (wr_en),
    .wr_row        (wr_row),
    .wr_byte       (wr_byte),
    .rd_row        (rd_row)
  );

  // Byte banks of the store.
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    cbb_bank #(
      .ROW_W (RW)
    ) u_bank (
      .clk       (clk),
      .wr_en     (wr_en[b]),
      .wr_row    (wr_row[b]),
      .wr_byte   (wr_byte[b]),
      .rd_row    (rd_row[b]),
      .rd_byte_r (bank_byte[b])
    );
  end

  // Read alignment and result register.
  cbb_outreg #(
    .STORE_DEPTH    (STORE_DEPTH),
    .BYTES_PER_ITEM (BYTES_PER_ITEM)
  ) u_outreg (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .moved              (moved),
    .fill               (fill),
    .free               (free),
    .rpos               (rpos),
    .wpos               (wpos),
    .bank_byte          (bank_byte),
    .out_strobe         (out_strobe),
    .out_accepted       (out_accepted),
    .out_read_data      (out_read_data),
    .out_moved          (out_moved),
    .out_fill_level     (out_fill_level),
    .out_free_space     (out_free_space),
    .out_read_position  (out_read_position),
    .out_write_position (out_write_position)
  );

`ifndef SYNTHESIS
  // Every accepted request yields a result strobe.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !cfg_wr_en) |-> ##2 out_strobe)
    else $error("request without result");

  // A rejected request moves nothing and returns no data.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_accepted) |-> (out_moved == '0 && out_read_data == '0))
    else $error("rejected request moved data");

  // Fill level and free space together never exceed the store.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (((CW+1)'(out_fill_level) + (CW+1)'(out_free_space)) <=
                    (CW+1)'(STORE_DEPTH)))
    else $error("fill and free space exceed store depth");
`endif

endmodule
`default_nettype wire
